[rtl/rgb_led_fade_controller_top_macros.svh]
// Assertion helpers for the RTL of the LED fade controller.
// Every use assumes the enclosing module has ports named aclk and aresetn.
`ifndef RGB_LED_FADE_CONTROLLER_TOP_MACROS_SVH
`define RGB_LED_FADE_CONTROLLER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define RLFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define RLFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RLFC_ASSERT(lbl, prop, msg)
`define RLFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/rlfc_pkg.sv]
`default_nettype none

package rlfc_pkg;

    localparam int LEVEL_BITS_DEF = 8;
    localparam int DELAY_BITS_DEF = 16;
    localparam int ACTION_BITS    = 3;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 8;
    localparam int NUM_CHANNELS   = 3;
    localparam int FULL_SCALE     = 255;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_TICK  = 3'd0,
        ACT_SET   = 3'd1,
        ACT_FADE  = 3'd2,
        ACT_OFF   = 3'd3,
        ACT_ON    = 3'd4,
        ACT_ONOFF = 3'd5
    } action_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RED   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_GREEN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_BLUE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RED   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_GREEN = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_BLUE  = 3'd5;

endpackage

`default_nettype wire

[rtl/rgb_led_fade_controller_top.sv]
// Three-channel LED level controller with linear fade. Each input word carries one
// command (tick, set levels, fade, all off, all on, per-channel on/off) and produces
// exactly one result word with the three drive levels after the command, an accepted
// flag and a fading flag. Set and fade are carried out only when every value lies in
// the channel's [min, max] window from the configuration registers; a fade then moves
// each channel one count toward its target on a tick, the first step on the first
// tick after the command and later steps every max(1, fade_delay) ticks. The block
// takes one word per clock: the command is decoded and the new state computed in
// combinational compare-and-step logic, and the result sits in one output register,
// so s_ready stays high as long as that register is empty or being read. The result
// of a word appears on the output in the cycle after the word is accepted. The range
// registers (index 0 to 2 minimum red/green/blue, 3 to 5 maximum) are written through
// cfg_wr_en, cfg_index and cfg_wdata and should only change while no word is in flight.
`default_nettype none

module rgb_led_fade_controller_top #(
    parameter int LEVEL_BITS = rlfc_pkg::LEVEL_BITS_DEF,
    parameter int DELAY_BITS = rlfc_pkg::DELAY_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration write port.
    input  wire logic                               cfg_wr_en,
    input  wire logic [rlfc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rlfc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    // Command channel.
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [rlfc_pkg::ACTION_BITS-1:0]   s_action,
    input  wire logic [LEVEL_BITS-1:0]              s_red,
    input  wire logic [LEVEL_BITS-1:0]              s_green,
    input  wire logic [LEVEL_BITS-1:0]              s_blue,
    input  wire logic [DELAY_BITS-1:0]              s_fade_delay,
    // Result channel.
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [LEVEL_BITS-1:0]                   m_level_red,
    output logic [LEVEL_BITS-1:0]                   m_level_green,
    output logic [LEVEL_BITS-1:0]                   m_level_blue,
    output logic                                    m_accepted,
    output logic                                    m_fading
);
    import rlfc_pkg::*;

    localparam int RES_BITS = NUM_CHANNELS * LEVEL_BITS + 2;

    logic [NUM_CHANNELS-1:0][LEVEL_BITS-1:0] min_lvl;
    logic [NUM_CHANNELS-1:0][LEVEL_BITS-1:0] max_lvl;
    logic [NUM_CHANNELS-1:0][LEVEL_BITS-1:0] cmd_val;
    logic [NUM_CHANNELS-1:0][LEVEL_BITS-1:0] res_level;
    logic                                    res_accepted;
    logic                                    res_fading;
    logic                                    cmd_fire;
    logic [RES_BITS-1:0]                     res_word;
    logic [RES_BITS-1:0]                     out_word;

    // The output register frees up in the same cycle its word is taken.
    assign s_ready  = !m_valid || m_ready;
    assign cmd_fire = s_valid && s_ready;

    assign cmd_val[0] = s_red;
    assign cmd_val[1] = s_green;
    assign cmd_val[2] = s_blue;

    rlfc_cfg_regs #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .min_lvl   (min_lvl),
        .max_lvl   (max_lvl)
    );

    rlfc_core #(
        .LEVEL_BITS (LEVEL_BITS),
        .DELAY_BITS (DELAY_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_fire     (cmd_fire),
        .cmd_action   (s_action),
        .cmd_val      (cmd_val),
        .cmd_delay    (s_fade_delay),
        .min_lvl      (min_lvl),
        .max_lvl      (max_lvl),
        .res_level    (res_level),
        .res_accepted (res_accepted),
        .res_fading   (res_fading)
    );

    assign res_word = {res_level, res_accepted, res_fading};

    rlfc_out_reg #(
        .DATA_BITS (RES_BITS)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (cmd_fire),
        .load_data (res_word),
        .take      (m_ready),
        .out_valid (m_valid),
        .out_data  (out_word)
    );

    // Unpack in the same order the result word was packed.
    assign m_level_blue  = out_word[2*LEVEL_BITS+2 +: LEVEL_BITS];
    assign m_level_green = out_word[LEVEL_BITS+2   +: LEVEL_BITS];
    assign m_level_red   = out_word[2              +: LEVEL_BITS];
    assign m_accepted    = out_word[1];
    assign m_fading      = out_word[0];

endmodule

`default_nettype wire

[rtl/rlfc_cfg_regs.sv]
`default_nettype none

module rlfc_cfg_regs #(
    parameter int LEVEL_BITS = rlfc_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [rlfc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [rlfc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    output logic [rlfc_pkg::NUM_CHANNELS-1:0][LEVEL_BITS-1:0] min_lvl,
    output logic [rlfc_pkg::NUM_CHANNELS-1:0][LEVEL_BITS-1:0] max_lvl
);
    import rlfc_pkg::*;

    logic [NUM_CHANNELS-1:0][LEVEL_BITS-1:0] min_reg;
    logic [NUM_CHANNELS-1:0][LEVEL_BITS-1:0] max_reg;
    logic [LEVEL_BITS-1:0]                   wval;

    assign wval = LEVEL_BITS'(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= '0;
            max_reg <= {NUM_CHANNELS{LEVEL_BITS'(FULL_SCALE)}};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MIN_RED:   min_reg[0] <= wval;
                CFG_MIN_GREEN: min_reg[1] <= wval;
                CFG_MIN_BLUE:  min_reg[2] <= wval;
                CFG_MAX_RED:   max_reg[0] <= wval;
                CFG_MAX_GREEN: max_reg[1] <= wval;
                CFG_MAX_BLUE:  max_reg[2] <= wval;
                default: ;
            endcase
        end
    end

    assign min_lvl = min_reg;
    assign max_lvl = max_reg;

endmodule

`default_nettype wire

[rtl/rlfc_core.sv]
`default_nettype none

`include "rgb_led_fade_controller_top_macros.svh"

module rlfc_core #(
    parameter int LEVEL_BITS = rlfc_pkg::LEVEL_BITS_DEF,
    parameter int DELAY_BITS = rlfc_pkg::DELAY_BITS_DEF
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         cmd_fire,
    input  wire logic [rlfc_pkg::ACTION_BITS-1:0]             cmd_action,
    input  wire logic [rlfc_pkg::NUM_CHANNELS-1:0][LEVEL_BITS-1:0] cmd_val,
    input  wire logic [DELAY_BITS-1:0]                        cmd_delay,
    input  wire logic [rlfc_pkg::NUM_CHANNELS-1:0][LEVEL_BITS-1:0] min_lvl,
    input  wire logic [rlfc_pkg::NUM_CHANNELS-1:0][LEVEL_BITS-1:0] max_lvl,
    output logic [rlfc_pkg::NUM_CHANNELS-1:0][LEVEL_BITS-1:0] res_level,
    output logic                                              res_accepted,
    output logic                                              res_fading
);
    import rlfc_pkg::*;

    localparam logic [LEVEL_BITS-1:0] FULL_LVL = LEVEL_BITS'(FULL_SCALE);

    action_t                                 action;
    logic [NUM_CHANNELS-1:0][LEVEL_BITS-1:0] level_reg, level_next;
    logic [NUM_CHANNELS-1:0][LEVEL_BITS-1:0] target_reg, target_next;
    logic                                    fade_active_reg, fade_active_next;
    logic [DELAY_BITS-1:0]                   step_interval_reg, step_interval_next;
    logic [DELAY_BITS-1:0]                   tick_count_reg, tick_count_next;
    logic [NUM_CHANNELS-1:0][LEVEL_BITS-1:0] stepped;
    logic [NUM_CHANNELS-1:0][LEVEL_BITS-1:0] switched;
    logic [NUM_CHANNELS-1:0]                 in_window;
    logic                                    window_ok;
    logic                                    accepted;

    assign action = action_t'(cmd_action);

    // Per-channel window check, one-count step and on/off decode.
    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
        assign in_window[i] = (cmd_val[i] >= min_lvl[i]) && (cmd_val[i] <= max_lvl[i]);
        assign stepped[i]   = (level_reg[i] < target_reg[i]) ? level_reg[i] + 1'b1 :
                              (level_reg[i] > target_reg[i]) ? level_reg[i] - 1'b1 :
                              level_reg[i];
        assign switched[i]  = (cmd_val[i] != '0) ? FULL_LVL : '0;
    end

    assign window_ok = &in_window;

    always_comb begin
        level_next         = level_reg;
        target_next        = target_reg;
        fade_active_next   = fade_active_reg;
        step_interval_next = step_interval_reg;
        tick_count_next    = tick_count_reg;
        accepted           = 1'b1;
        unique case (action)
            ACT_TICK: begin
                if (fade_active_reg) begin
                    if (tick_count_reg == '0) begin
                        level_next       = stepped;
                        fade_active_next = (stepped != target_reg);
                        tick_count_next  = step_interval_reg - 1'b1;
                    end else begin
                        tick_count_next  = tick_count_reg - 1'b1;
                    end
                end
            end
            ACT_SET: begin
                if (window_ok) begin
                    level_next       = cmd_val;
                    target_next      = cmd_val;
                    fade_active_next = 1'b0;
                end else begin
                    accepted = 1'b0;
                end
            end
            ACT_FADE: begin
                if (window_ok) begin
                    target_next        = cmd_val;
                    step_interval_next = (cmd_delay == '0) ? DELAY_BITS'(1) : cmd_delay;
                    tick_count_next    = '0;
                    fade_active_next   = (level_reg != cmd_val);
                end else begin
                    accepted = 1'b0;
                end
            end
            ACT_OFF: begin
                level_next       = '0;
                fade_active_next = 1'b0;
            end
            ACT_ON: begin
                level_next       = {NUM_CHANNELS{FULL_LVL}};
                fade_active_next = 1'b0;
            end
            ACT_ONOFF: begin
                level_next       = switched;
                fade_active_next = 1'b0;
            end
            default: begin
                accepted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg         <= '0;
            target_reg        <= '0;
            fade_active_reg   <= 1'b0;
            step_interval_reg <= '0;
            tick_count_reg    <= '0;
        end else if (cmd_fire) begin
            level_reg         <= level_next;
            target_reg        <= target_next;
            fade_active_reg   <= fade_active_next;
            step_interval_reg <= step_interval_next;
            tick_count_reg    <= tick_count_next;
        end
    end

    assign res_level    = level_next;
    assign res_accepted = accepted;
    assign res_fading   = fade_active_next;

    // A running fade always has somewhere left to go.
    `RLFC_ASSERT(a_fade_not_at_target, !fade_active_reg || (level_reg != target_reg), "fade active at target")
    // The tick countdown never reaches the step interval during a fade.
    `RLFC_ASSERT(a_tick_below_interval, !fade_active_reg || (tick_count_reg < step_interval_reg), "tick count out of range")
    // All off forces every level to zero and stops the fade.
    `RLFC_ASSERT_NEXT(a_off_clears, cmd_fire && (action == ACT_OFF), (level_reg == '0) && !fade_active_reg, "all off left state behind")

endmodule

`default_nettype wire

[rtl/rlfc_out_reg.sv]
`default_nettype none

module rlfc_out_reg #(
    parameter int DATA_BITS = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire logic [DATA_BITS-1:0] load_data,
    input  wire logic                 take,
    output logic                      out_valid,
    output logic [DATA_BITS-1:0]      out_data
);
    logic                 valid_reg;
    logic [DATA_BITS-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire
